[hdl/assert_macros.svh]
// ------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers used by the checker file.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, held off while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Assert that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

[hdl/sclid_pkg.sv]
// ------------------------------------------------------------------------
// Sorted character list package
// Shared widths, codes, controller states and command types.
// ------------------------------------------------------------------------
package sclid_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 8;
    localparam int STATUS_W     = 2;
    localparam int COUNT_W      = 5;

    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_DELETED   = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;    // capture the request fields
        logic commit;  // update the list and capture the response
    } cmd_t;

    // Handshake status seen by the controller
    typedef struct packed {
        logic in_valid;
        logic out_ready;
    } hs_t;

endpackage

[hdl/sclid_req_if.sv]
// ------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one insert or delete request.
// ------------------------------------------------------------------------
interface sclid_req_if;
    logic                                valid;
    logic                                ready;
    logic                                req_type;
    logic signed [sclid_pkg::VALUE_W-1:0] value;

    modport source (output valid, output req_type, output value, input ready);
    modport sink (input valid, input req_type, input value, output ready);
endinterface

[hdl/sclid_rsp_if.sv]
// ------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying the status and entry count of a request.
// ------------------------------------------------------------------------
interface sclid_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sclid_pkg::STATUS_W-1:0] status;
    logic [sclid_pkg::COUNT_W-1:0]  entry_count;

    modport source (output valid, output status, output entry_count, input ready);
    modport sink (input valid, input status, input entry_count, output ready);
endinterface

[hdl/sclid_ctrl.sv]
// ------------------------------------------------------------------------
// Sorted character list controller
// Two-state sequencer plus the response valid flag.
// ------------------------------------------------------------------------
module sclid_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  sclid_pkg::hs_t    hs,
    output logic              in_ready,
    output logic              out_valid,
    output sclid_pkg::cmd_t   cmd
);

    sclid_pkg::state_t state_reg;
    sclid_pkg::state_t state_next;
    logic              out_valid_reg;
    logic              out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sclid_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        in_ready       = 1'b0;

        // drop the response once it is taken
        if (out_valid_reg && hs.out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            sclid_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (hs.in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = sclid_pkg::S_EXEC;
                end
            end
            sclid_pkg::S_EXEC:
            begin
                // hold until the response slot is free
                if (!out_valid_reg || hs.out_ready)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sclid_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sclid_pkg::S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

[hdl/sclid_dp.sv]
// ------------------------------------------------------------------------
// Sorted character list datapath
// Row of entry cells with per-cell compare and neighbor shift.
// ------------------------------------------------------------------------
module sclid_dp #(
    parameter int CAPACITY = sclid_pkg::CAPACITY_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sclid_pkg::cmd_t                       cmd,
    input  logic                                  req_type,
    input  logic signed [sclid_pkg::VALUE_W-1:0]  value,
    output sclid_pkg::status_t                    status,
    output logic [sclid_pkg::COUNT_W-1:0]         entry_count
);

    localparam int CntW = $clog2(CAPACITY + 1);

    logic signed [sclid_pkg::VALUE_W-1:0] entry_reg  [CAPACITY];
    logic signed [sclid_pkg::VALUE_W-1:0] entry_next [CAPACITY];
    logic [CntW-1:0]                      count_reg;
    logic [CntW-1:0]                      count_next;
    logic                                 req_type_reg;
    logic signed [sclid_pkg::VALUE_W-1:0] value_reg;
    sclid_pkg::status_t                   status_reg;
    sclid_pkg::status_t                   status_next;
    logic [sclid_pkg::COUNT_W-1:0]        entry_count_reg;
    logic [CntW+sclid_pkg::COUNT_W-1:0]   count_wide;

    logic [CAPACITY-1:0] ge;      // live cell not smaller than the value
    logic [CAPACITY-1:0] eq;      // live cell equal to the value
    logic [CAPACITY-1:0] at_end;  // first free cell
    logic                found;
    logic                full;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            assign ge[g]     = (CntW'(g) < count_reg) && (entry_reg[g] >= value_reg);
            assign eq[g]     = (CntW'(g) < count_reg) && (entry_reg[g] == value_reg);
            assign at_end[g] = (CntW'(g) == count_reg);

            // Sorted order makes ge a run of ones from the slot point to the last live entry,
            // so each cell decides from itself and its neighbors alone.
            if (g == 0)
            begin : g_first
                always_comb
                begin
                    if (req_type_reg == sclid_pkg::REQ_INSERT)
                    begin
                        entry_next[g] = (ge[g] || at_end[g]) ? value_reg : entry_reg[g];
                    end
                    else
                    begin
                        if (CAPACITY > 1)
                        begin
                            entry_next[g] = ge[g] ? entry_reg[(g + 1) % CAPACITY]
                                                  : entry_reg[g];
                        end
                        else
                        begin
                            entry_next[g] = entry_reg[g];
                        end
                    end
                end
            end
            else if (g == CAPACITY - 1)
            begin : g_last
                always_comb
                begin
                    if (req_type_reg == sclid_pkg::REQ_INSERT)
                    begin
                        entry_next[g] = ge[g-1] ? entry_reg[g-1]
                                      : (ge[g] || at_end[g]) ? value_reg : entry_reg[g];
                    end
                    else
                    begin
                        entry_next[g] = entry_reg[g];
                    end
                end
            end
            else
            begin : g_mid
                always_comb
                begin
                    if (req_type_reg == sclid_pkg::REQ_INSERT)
                    begin
                        entry_next[g] = ge[g-1] ? entry_reg[g-1]
                                      : (ge[g] || at_end[g]) ? value_reg : entry_reg[g];
                    end
                    else
                    begin
                        entry_next[g] = ge[g] ? entry_reg[g+1] : entry_reg[g];
                    end
                end
            end
        end
    endgenerate

    assign found = |eq;
    assign full  = (count_reg == CntW'(CAPACITY));

    always_comb
    begin
        count_next = count_reg;
        if (req_type_reg == sclid_pkg::REQ_INSERT)
        begin
            if (full)
            begin
                status_next = sclid_pkg::ST_FULL;
            end
            else
            begin
                status_next = sclid_pkg::ST_INSERTED;
                count_next  = count_reg + CntW'(1);
            end
        end
        else
        begin
            if (found)
            begin
                status_next = sclid_pkg::ST_DELETED;
                count_next  = count_reg - CntW'(1);
            end
            else
            begin
                status_next = sclid_pkg::ST_NOT_FOUND;
            end
        end
    end

    assign count_wide = (CntW + sclid_pkg::COUNT_W)'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_type_reg <= req_type;
            value_reg    <= value;
        end
        if (cmd.commit)
        begin
            status_reg      <= status_next;
            entry_count_reg <= count_wide[sclid_pkg::COUNT_W-1:0];
            if ((req_type_reg == sclid_pkg::REQ_INSERT && !full) ||
                (req_type_reg == sclid_pkg::REQ_DELETE && found))
            begin
                for (int i = 0; i < CAPACITY; i++)
                begin
                    entry_reg[i] <= entry_next[i];
                end
            end
        end
    end

    assign status      = status_reg;
    assign entry_count = entry_count_reg;

endmodule

[hdl/sorted_char_list_insert_delete_unit.sv]
// ------------------------------------------------------------------------
// Sorted character list insert/delete unit
// Bounded ascending list of signed characters with insert and delete.
// ------------------------------------------------------------------------
// Each request on req inserts a signed character ahead of the first stored
// entry that is not smaller than it (status inserted, or full when the list
// already holds CAPACITY entries), or deletes the first entry equal to it
// (status deleted, or not found, also on an empty list). Exactly one
// response per request appears on rsp with the status and the entry count
// after the request, the count carrying its low five bits. A request is
// first registered; then every cell compares itself with the value and
// takes its own value, its neighbor's or the new one in the same clock.
// req is ready again right after the update, so a new request is taken
// while the last response still waits on rsp; the update of that next
// request holds until the response register is free.
// The entries need no clearing after reset, only the count is reset.
module sorted_char_list_insert_delete_unit #(
    parameter int CAPACITY = sclid_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    sclid_req_if.sink         req,
    sclid_rsp_if.source       rsp
);

    sclid_pkg::cmd_t   cmd;
    sclid_pkg::hs_t    hs;
    sclid_pkg::status_t status;

    assign hs.in_valid  = req.valid;
    assign hs.out_ready = rsp.ready;

    // Sequencer: register the request, then commit when rsp has room.
    sclid_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .hs        (hs),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .cmd       (cmd)
    );

    // Entry cells, count and response payload registers.
    sclid_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req.req_type),
        .value       (req.value),
        .status      (status),
        .entry_count (rsp.entry_count)
    );

    assign rsp.status = status;

endmodule

[hdl/sclid_checker.sv]
// ------------------------------------------------------------------------
// Sorted character list port checker
// Watches the request and response ports of the unit over time.
// ------------------------------------------------------------------------
`include "assert_macros.svh"

module sclid_checker #(
    parameter int CAPACITY = sclid_pkg::CAPACITY_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [sclid_pkg::STATUS_W-1:0] rsp_status,
    input logic [sclid_pkg::COUNT_W-1:0]  rsp_entry_count
);

    localparam logic [sclid_pkg::COUNT_W-1:0] FullCount = sclid_pkg::COUNT_W'(CAPACITY);

    logic req_xfer;
    logic full_rsp;

    assign req_xfer = req_valid && req_ready;
    assign full_rsp = rsp_valid && (rsp_status == sclid_pkg::ST_FULL);

    // response holds until its transfer
    `ASSERT_CLK(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped")
    // one request at a time
    `ASSERT_CLK(a_req_busy, clk, rst_n, req_xfer |=> !req_ready, "req ready while busy")
    // a fresh response follows an accepted request
    `ASSERT_CLK(a_rsp_rise, clk, rst_n, $rose(rsp_valid) |-> $past(req_xfer, 2), "rsp without request")
    // a full report carries the capacity as count
    `ASSERT_NEVER(a_full_cnt, clk, rst_n, full_rsp && rsp_entry_count != FullCount, "full with wrong count")

endmodule

bind sorted_char_list_insert_delete_unit sclid_checker #(
    .CAPACITY (CAPACITY)
) u_sclid_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count)
);

[test/tb_top.sv]
// ------------------------------------------------------------------------
// Sorted character list unit testbench
// Streams insert and delete requests into the unit, predicts every
// response from a sorted queue of signed characters, and checks each
// status and entry count in order under random gaps and stalls.
// ------------------------------------------------------------------------
module tb_top;

    import sclid_pkg::*;

    localparam int CAP              = CAPACITY_DEF;
    localparam int PHASES           = 7;
    localparam int PHASE_ITEMS      = 200;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int LONG_HOLD_AT     = 600;
    localparam int LONG_HOLD_CYCLES = 150;
    localparam int TAIL_CYCLES      = 10;

    // One pending request: its fields, the idle cycles ahead of it, and
    // whether the sender must first see every response come back.
    typedef struct {
        logic                      req_type;
        logic signed [VALUE_W-1:0] value;
        int unsigned               gap;
        bit                        drain;
    } list_req_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   entry_count;
    } list_rsp_t;

    logic clk;
    logic rst_n;

    sclid_req_if req_ch ();
    sclid_rsp_if rsp_ch ();

    sorted_char_list_insert_delete_unit #(
        .CAPACITY (CAP)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Request stream built up front, and the responses it must produce.
    list_req_t                 pend_q[$];
    list_rsp_t                 expected_rsp_q[$];

    // Sorted contents as the unit should hold them, lowest first.
    logic signed [VALUE_W-1:0] list_entries[$];

    // Membership shadow used only to steer the stimulus toward hits.
    logic signed [VALUE_W-1:0] gen_pool[$];

    list_req_t   cur_item;
    bit          have_cur;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned hold_left;
    logic        req_fire;
    logic        rsp_fire;
    int unsigned req_total;
    int unsigned rsp_total;
    int unsigned fail_count;
    int unsigned idle_cycles;
    int unsigned status_seen[4];
    int unsigned peak_count;

    // --------------------------------------------------------------------
    // Predict one request against the sorted list and update it.
    // Insert goes ahead of the first entry not smaller than the value, so
    // duplicates land in front of their equals; delete drops the first
    // exact match. The count wraps to the width of the response field.
    // --------------------------------------------------------------------
    function automatic list_rsp_t predict_request(input logic rtype,
                                                  input logic signed [VALUE_W-1:0] v);
        list_rsp_t r;
        int        pos;
        pos = 0;
        if (rtype == REQ_INSERT)
        begin
            if (list_entries.size() >= CAP)
                r.status = ST_FULL;
            else
            begin
                while (pos < list_entries.size() && v > list_entries[pos])
                    pos++;
                list_entries.insert(pos, v);
                r.status = ST_INSERTED;
            end
        end
        else
        begin
            while (pos < list_entries.size() && list_entries[pos] != v)
                pos++;
            if (pos >= list_entries.size())
                r.status = ST_NOT_FOUND;
            else
            begin
                list_entries.delete(pos);
                r.status = ST_DELETED;
            end
        end
        r.entry_count = COUNT_W'(list_entries.size());
        return r;
    endfunction

    // Queue one request and track which values the list will hold.
    task automatic add_request(input logic rtype, input logic signed [VALUE_W-1:0] v,
                               input int unsigned gap, input bit drain);
        list_req_t item;
        bit        found;
        item.req_type = rtype;
        item.value    = v;
        item.gap      = gap;
        item.drain    = drain;
        pend_q.push_back(item);
        if (rtype == REQ_INSERT)
        begin
            if (gen_pool.size() < CAP)
                gen_pool.push_back(v);
        end
        else
        begin
            found = 1'b0;
            for (int i = 0; i < gen_pool.size() && !found; i++)
            begin
                if (gen_pool[i] == v)
                begin
                    gen_pool.delete(i);
                    found = 1'b1;
                end
            end
        end
    endtask

    // --------------------------------------------------------------------
    // Clock and reset
    // --------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        // Hold every input at a known value from time zero.
        rst_n           = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.req_type = REQ_INSERT;
        req_ch.value    = '0;
        rsp_ch.ready    = 1'b0;
        repeat (11) @(posedge clk);
        // Release away from the rising edge; the driver still sees reset
        // on this falling edge and starts on the next one.
        @(negedge clk);
        rst_n <= 1'b1;
    end

    // --------------------------------------------------------------------
    // Request driver: offer the next queued item after its gap, keep valid
    // high until the transfer, and hold a drain item back until every
    // outstanding response has arrived.
    // --------------------------------------------------------------------
    always @(negedge clk)
    begin : request_driver
        logic offer;
        offer = req_ch.valid;
        if (!rst_n)
            offer = 1'b0;
        else
        begin
            // Drop the item that was transferred on the last rising edge.
            if (req_fire)
                offer = 1'b0;
            if (!offer)
            begin
                if (!have_cur && pend_q.size() != 0
                    && !(pend_q[0].drain && expected_rsp_q.size() != 0))
                begin
                    cur_item = pend_q.pop_front();
                    have_cur = 1'b1;
                    gap_left = cur_item.gap;
                end
                if (have_cur)
                begin
                    if (gap_left != 0)
                        gap_left--;
                    else
                    begin
                        req_ch.req_type <= cur_item.req_type;
                        req_ch.value    <= cur_item.value;
                        have_cur = 1'b0;
                        offer    = 1'b1;
                    end
                end
            end
        end
        req_ch.valid <= offer;
    end

    // --------------------------------------------------------------------
    // Response sink: after each transfer draw a stall, with stretches of
    // no stall at all, and once hold ready low long enough for the unit to
    // fill and back-pressure the request side.
    // --------------------------------------------------------------------
    always @(negedge clk)
    begin : response_sink
        logic take;
        take = 1'b0;
        if (rst_n)
        begin
            if (rsp_fire)
            begin
                if (rsp_total == LONG_HOLD_AT)
                    hold_left = LONG_HOLD_CYCLES;
                else if ((rsp_total / 150) % 3 == 0)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 11);
            end
            if (hold_left != 0)
                hold_left--;
            else if (stall_left != 0)
                stall_left--;
            else
                take = 1'b1;
        end
        rsp_ch.ready <= take;
    end

    // --------------------------------------------------------------------
    // Monitor: check responses against the oldest prediction, predict each
    // accepted request, and watch for a stalled run.
    // --------------------------------------------------------------------
    always @(posedge clk)
    begin : transfer_monitor
        list_rsp_t want;
        req_fire <= rst_n && req_ch.valid && req_ch.ready;
        rsp_fire <= rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rst_n)
        begin
            // Check the response first: it always belongs to an earlier
            // request than one accepted on the same edge.
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                rsp_total++;
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response with no request pending: status %0d, entry_count %0d",
                           rsp_ch.status, rsp_ch.entry_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    status_seen[want.status]++;
                    if (want.entry_count > peak_count)
                        peak_count = want.entry_count;
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status mismatch: expected %0d, actual %0d",
                               want.status, rsp_ch.status);
                        fail_count++;
                    end
                    if (rsp_ch.entry_count !== want.entry_count)
                    begin
                        $error("entry_count mismatch: expected %0d, actual %0d",
                               want.entry_count, rsp_ch.entry_count);
                        fail_count++;
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                req_total++;
                expected_rsp_q.push_back(predict_request(req_ch.req_type, req_ch.value));
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transfer for %0d cycles, %0d responses outstanding",
                         idle_cycles, expected_rsp_q.size());
                $display("** sorted_char_list_insert_delete_unit: FAILED **");
                $finish;
            end
        end
    end

    // --------------------------------------------------------------------
    // Stimulus and end of run
    // --------------------------------------------------------------------
    initial
    begin : stimulus
        logic signed [VALUE_W-1:0] v;
        logic                      rtype;
        int unsigned               target;
        int unsigned               gap;
        int unsigned               pick;

        have_cur    = 1'b0;
        gap_left    = 0;
        stall_left  = 0;
        hold_left   = 0;
        req_fire    = 1'b0;
        rsp_fire    = 1'b0;
        req_total   = 0;
        rsp_total   = 0;
        fail_count  = 0;
        idle_cycles = 0;
        peak_count  = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed: delete on an empty list, the value extremes, a
        // duplicate that must land ahead of its equal, a miss on a
        // non-empty list, fill to capacity, insert into a full list, and
        // delete from a full one.
        add_request(REQ_DELETE, 8'sd0, $urandom_range(0, 11), 1'b0);
        add_request(REQ_INSERT, 8'sd127, $urandom_range(0, 11), 1'b0);
        add_request(REQ_INSERT, -8'sd128, $urandom_range(0, 11), 1'b0);
        add_request(REQ_INSERT, 8'sd0, $urandom_range(0, 11), 1'b0);
        add_request(REQ_INSERT, -8'sd1, $urandom_range(0, 11), 1'b0);
        add_request(REQ_INSERT, 8'sd1, $urandom_range(0, 11), 1'b0);
        add_request(REQ_INSERT, 8'sd0, $urandom_range(0, 11), 1'b0);
        add_request(REQ_DELETE, 8'sd5, $urandom_range(0, 11), 1'b0);
        add_request(REQ_DELETE, 8'sd0, $urandom_range(0, 11), 1'b0);
        add_request(REQ_DELETE, -8'sd128, $urandom_range(0, 11), 1'b0);
        add_request(REQ_DELETE, 8'sd127, $urandom_range(0, 11), 1'b0);
        while (gen_pool.size() < CAP)
            add_request(REQ_INSERT, VALUE_W'($urandom_range(0, 255)),
                        $urandom_range(0, 11), 1'b0);
        add_request(REQ_INSERT, 8'sd100, $urandom_range(0, 11), 1'b0);
        add_request(REQ_DELETE, -8'sd1, $urandom_range(0, 11), 1'b0);

        // Random phases alternate between driving the list toward full
        // and toward a fill equal to the phase number. Deletes mostly hit a
        // stored value; inserts favor a narrow band so duplicates are common. Each
        // phase opens with a drain so the sender waits out every response once.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            target = (phase % 2 == 0) ? CAP : phase;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (phase == 1 || phase == 4)
                    gap = 0;
                else if (phase == 3)
                    gap = $urandom_range(0, 2);
                else
                    gap = $urandom_range(0, 11);
                if (gen_pool.size() < target)
                    rtype = ($urandom_range(0, 99) < 70) ? REQ_INSERT : REQ_DELETE;
                else
                    rtype = ($urandom_range(0, 99) < 30) ? REQ_INSERT : REQ_DELETE;
                pick = $urandom_range(0, 9);
                if (rtype == REQ_DELETE)
                begin
                    if (gen_pool.size() != 0 && pick != 0)
                        v = gen_pool[$urandom_range(0, gen_pool.size() - 1)];
                    else
                        v = VALUE_W'($urandom_range(0, 255));
                end
                else if (pick < 4)
                    v = VALUE_W'(int'($urandom_range(0, 6)) - 3);
                else if (pick == 4)
                    v = $urandom_range(0, 1) ? 8'sd127 : -8'sd128;
                else
                    v = VALUE_W'($urandom_range(0, 255));
                add_request(rtype, v, gap, n == 0);
            end
        end

        // Wait for the last transfer, then for every response, then let
        // the unit settle so a stray extra response would still show up.
        @(posedge rst_n);
        while (pend_q.size() != 0 || have_cur || req_ch.valid)
            @(negedge clk);
        while (expected_rsp_q.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);

        if (expected_rsp_q.size() != 0)
        begin
            $error("%0d responses never arrived", expected_rsp_q.size());
            fail_count++;
        end
        $display("Ran %0d requests: %0d inserted, %0d rejected as full, %0d deleted, %0d missed.",
                 req_total, status_seen[ST_INSERTED], status_seen[ST_FULL],
                 status_seen[ST_DELETED], status_seen[ST_NOT_FOUND]);
        $display("List held up to %0d of %0d entries; %0d check failures.",
                 peak_count, CAP, fail_count);
        if (fail_count == 0)
            $display("** sorted_char_list_insert_delete_unit: PASSED **");
        else
            $display("** sorted_char_list_insert_delete_unit: FAILED **");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/sclid_pkg.sv
hdl/sclid_req_if.sv
hdl/sclid_rsp_if.sv
hdl/sclid_ctrl.sv
hdl/sclid_dp.sv
hdl/sorted_char_list_insert_delete_unit.sv
hdl/sclid_checker.sv
test/tb_top.sv
